/* rtl/lrm_pkg.sv */
// Shared constants and types for the Lehmer random range generator.
`default_nettype none
package lrm_pkg;

  localparam int unsigned StateW = 31;
  localparam int unsigned MultW  = 15;
  localparam int unsigned ProdW  = StateW + MultW;
  localparam int unsigned AmtW   = 16;
  localparam int unsigned CntW   = 5;

  localparam logic [MultW-1:0]  LehmerMult = 15'd16807;
  localparam logic [StateW-1:0] LehmerMod  = 31'h7FFF_FFFF;
  localparam logic [StateW-1:0] StateReset = 31'd1;

  typedef logic [StateW-1:0] state_t;
  typedef logic [AmtW-1:0]   amount_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctrl_t;

endpackage
`default_nettype wire

/* rtl/lrm_mulmod.sv */
// Two-stage multiply by 16807 and fold-reduce modulo 2^31-1.
`default_nettype none
module lrm_mulmod (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire lrm_pkg::state_t state_i,
  output logic                done_o,
  output lrm_pkg::state_t     result_o
);

  logic [lrm_pkg::ProdW-1:0]    prod_q;
  logic                         prod_vld_q;
  logic                         res_vld_q;
  lrm_pkg::state_t              res_q;
  logic [lrm_pkg::StateW:0]     sum;
  logic [lrm_pkg::StateW:0]     sum_red;

  always_comb begin
    sum = {1'b0, prod_q[lrm_pkg::StateW-1:0]}
        + {{(lrm_pkg::StateW + 1 - lrm_pkg::MultW){1'b0}}, prod_q[lrm_pkg::ProdW-1:lrm_pkg::StateW]};
    if (sum >= {1'b0, lrm_pkg::LehmerMod}) begin
      sum_red = sum - {1'b0, lrm_pkg::LehmerMod};
    end else begin
      sum_red = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= start_i;
      res_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= {{lrm_pkg::MultW{1'b0}}, state_i} * {{lrm_pkg::StateW{1'b0}}, lrm_pkg::LehmerMult};
    end
    if (prod_vld_q) begin
      res_q <= sum_red[lrm_pkg::StateW-1:0];
    end
  end

  assign done_o   = res_vld_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

/* rtl/lrm_divider.sv */
// Bit-serial restoring remainder unit: 31-bit dividend by 16-bit divisor.
`default_nettype none
module lrm_divider (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lrm_pkg::unit_ctrl_t ctrl_i,
  input  wire lrm_pkg::state_t  dividend_i,
  input  wire lrm_pkg::amount_t divisor_i,
  output lrm_pkg::unit_ctrl_t   ctrl_o,
  output lrm_pkg::amount_t      remainder_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [lrm_pkg::CntW-1:0]   cnt_q;
  lrm_pkg::state_t            dvd_q;
  lrm_pkg::amount_t           dvs_q;
  lrm_pkg::amount_t           rem_q;
  logic [lrm_pkg::AmtW:0]     trial;
  logic [lrm_pkg::AmtW:0]     diff;
  lrm_pkg::amount_t           rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[lrm_pkg::StateW-1]};
    diff  = trial - {1'b0, dvs_q};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[lrm_pkg::AmtW-1:0];
    end else begin
      rem_d = trial[lrm_pkg::AmtW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= lrm_pkg::CntW'(lrm_pkg::StateW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == lrm_pkg::CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[lrm_pkg::StateW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign ctrl_o.start = busy_q;
  assign ctrl_o.done  = done_q;
  assign remainder_o  = rem_q;

endmodule
`default_nettype wire

/* rtl/lehmer_random_modulo.sv */
// Top level: Park-Miller generator with a range reduction per request.
//
// Usage:
// The slave stream carries one request item per bound in s_axis_tdata_i.
// Each accepted item advances the 31-bit state by a multiply with 16807
// modulo 2^31-1 and returns one result item on the master stream holding
// the new state modulo the bound and the new state itself. A zero bound
// gives a value of 0 with tuser set, and the state still advances.
// An accepted item passes through the multiply-reduce unit, then the
// bit-serial remainder unit, which handles one dividend bit per cycle,
// and is then handed off to the output register.
// One item is worked on at a time; s_axis_tready_o is high only between
// items, so a new item is not accepted before the last result has been
// handed off to the output register.
// A finished result sits in an output register; while the receiver
// stalls it holds, and the block may still accept and compute the next
// item, which then waits until the register is free.
// Reset sets the state to 1 and empties the output register.
`default_nettype none
module lehmer_random_modulo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] amount
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // [15:0] value, [46:16] new_state, [47] zero
  output logic             m_axis_tuser_o    // [0] divide_error
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StHold = 2'd3;

  logic [1:0]          st_q, st_d;
  lrm_pkg::state_t     state_q;
  lrm_pkg::amount_t    amount_q;
  logic                out_vld_q;
  lrm_pkg::amount_t    out_value_q;
  lrm_pkg::state_t     out_state_q;
  logic                out_err_q;

  logic                in_acc;
  logic                mm_done;
  lrm_pkg::state_t     mm_result;
  lrm_pkg::unit_ctrl_t div_ctrl_in;
  lrm_pkg::unit_ctrl_t div_ctrl_out;
  lrm_pkg::amount_t    div_rem;
  logic                out_load;
  logic                amt_zero;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign amt_zero = (amount_q == '0);
  assign out_load = (st_q == StHold) && (!out_vld_q || m_axis_tready_i);

  assign div_ctrl_in.start = (st_q == StMul) && mm_done;
  assign div_ctrl_in.done  = 1'b0;

  lrm_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .state_i  (state_q),
    .done_o   (mm_done),
    .result_o (mm_result)
  );

  lrm_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl_in),
    .dividend_i  (mm_result),
    .divisor_i   (amount_q),
    .ctrl_o      (div_ctrl_out),
    .remainder_o (div_rem)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (in_acc) begin
          st_d = StMul;
        end
      end
      StMul: begin
        if (mm_done) begin
          st_d = StDiv;
        end
      end
      StDiv: begin
        if (div_ctrl_out.done) begin
          st_d = StHold;
        end
      end
      StHold: begin
        if (out_load) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      state_q   <= lrm_pkg::StateReset;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if ((st_q == StMul) && mm_done) begin
        state_q <= mm_result;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      amount_q <= s_axis_tdata_i;
    end
    if (out_load) begin
      out_value_q <= amt_zero ? '0 : div_rem;
      out_state_q <= state_q;
      out_err_q   <= amt_zero;
    end
  end

  assign s_axis_tready_o = (st_q == StIdle);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_state_q, out_value_q};
  assign m_axis_tuser_o  = out_err_q;

endmodule
`default_nettype wire

/* rtl/lrm_checker.sv */
// Port-level checks for the Lehmer random range generator and their binding.
`default_nettype none
module lrm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [15:0] s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i == s_axis_tdata_i);

  // A stalled result item keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result item changed while stalled");

  // Only one item is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input accepted again right after an accept");

  // A zero bound reports a zero value.
  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o[15:0] == 16'd0))
    else $error("divide error with nonzero value");

  // The reported state never reaches zero or the modulus.
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o[46:16] != 31'd0) && (m_axis_tdata_o[46:16] != 31'h7FFF_FFFF))
    else $error("generator state out of range");

endmodule

bind lehmer_random_modulo lrm_checker u_lrm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire
